>>> hdl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int ACTION_W    = 2;
  localparam int TAG_W       = 16;
  localparam int PRIO_W      = 8;
  localparam int TREAT_W     = 16;
  localparam int STATUS_W    = 2;
  localparam int RANK_W      = 5;
  localparam int MAX_RESULTS = 16;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TAG_W-1:0]    tag;
    logic [PRIO_W-1:0]   priority_req;
    logic [TREAT_W-1:0]  treatment;
  } cmd_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   rank;
    logic [TAG_W-1:0]    out_tag;
    logic [PRIO_W-1:0]   out_priority;
    logic [TREAT_W-1:0]  out_treatment;
    logic                last;
  } res_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLY,
    ST_DUMP,
    ST_SPIN
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic rotate;
    logic show_entry;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic dump_last;
    logic rot_last;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/spq_dpath.sv
`default_nettype none

module spq_dpath #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spq_pkg::cmd_item_t cmd,
  input  wire spq_pkg::dp_cmd_t   dcmd,
  output spq_pkg::dp_stat_t       dstat,
  output spq_pkg::res_item_t      res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $clog2(DEPTH);

  typedef struct packed {
    logic [spq_pkg::TAG_W-1:0]   tag;
    logic [spq_pkg::PRIO_W-1:0]  prio;
    logic [spq_pkg::TREAT_W-1:0] treat;
  } entry_t;

  entry_t                      slot [DEPTH];
  entry_t                      new_entry;
  logic [DEPTH-1:0]            ahead;
  logic [CW-1:0]               count;
  logic [RW-1:0]               rot;
  logic [spq_pkg::RANK_W-1:0]  rank_q;
  logic [spq_pkg::RANK_W-1:0]  emit_n;
  logic [spq_pkg::STATUS_W-1:0] status_q;
  logic                        full;
  logic                        do_insert;

  assign new_entry.tag   = cmd.tag;
  assign new_entry.prio  = cmd.priority_req;
  assign new_entry.treat = cmd.treatment;

  assign full      = (count == CW'(DEPTH));
  assign do_insert = dcmd.accept && (cmd.action == spq_pkg::ACT_INSERT) && !full;

  // The stored entries stay sorted, so the slots that rank before the new
  // entry form a prefix; the new entry lands just after it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    assign ahead[i] = (CW'(i) < count) &&
                      ((slot[i].prio < new_entry.prio) ||
                       ((slot[i].prio == new_entry.prio) &&
                        (slot[i].treat < new_entry.treat)));

    always_ff @(posedge clk) begin
      if (do_insert) begin
        if (!ahead[i]) begin
          if (i == 0) begin
            slot[i] <= new_entry;
          end else if (ahead[(i + DEPTH - 1) % DEPTH]) begin
            slot[i] <= new_entry;
          end else begin
            slot[i] <= slot[(i + DEPTH - 1) % DEPTH];
          end
        end
      end else if (dcmd.rotate) begin
        slot[i] <= slot[(i + 1) % DEPTH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rot      <= '0;
      rank_q   <= '0;
      emit_n   <= '0;
      status_q <= spq_pkg::STATUS_OK;
    end else if (dcmd.accept) begin
      case (cmd.action)
        spq_pkg::ACT_INSERT: begin
          if (full) begin
            status_q <= spq_pkg::STATUS_FULL;
          end else begin
            status_q <= spq_pkg::STATUS_OK;
            count    <= count + CW'(1);
          end
        end
        spq_pkg::ACT_CLEAR: begin
          status_q <= spq_pkg::STATUS_OK;
          count    <= '0;
        end
        spq_pkg::ACT_DUMP: begin
          status_q <= (count == '0) ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_OK;
          rank_q   <= spq_pkg::RANK_W'(1);
          rot      <= '0;
          emit_n   <= (int'(count) > spq_pkg::MAX_RESULTS) ?
                      spq_pkg::RANK_W'(spq_pkg::MAX_RESULTS) : spq_pkg::RANK_W'(count);
        end
        default: begin
        end
      endcase
    end else if (dcmd.rotate) begin
      rot    <= rot + RW'(1);
      rank_q <= rank_q + spq_pkg::RANK_W'(1);
    end
  end

  assign dstat.empty     = (count == '0);
  assign dstat.dump_last = (rank_q == emit_n);
  assign dstat.rot_last  = (rot == RW'(DEPTH - 1));

  always_comb begin
    if (dcmd.show_entry) begin
      res.status        = spq_pkg::STATUS_OK;
      res.rank          = rank_q;
      res.out_tag       = slot[0].tag;
      res.out_priority  = slot[0].prio;
      res.out_treatment = slot[0].treat;
      res.last          = (rank_q == emit_n);
    end else begin
      res.status        = status_q;
      res.rank          = '0;
      res.out_tag       = '0;
      res.out_priority  = '0;
      res.out_treatment = '0;
      res.last          = 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= DEPTH)
    else $error("entry count exceeds depth");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    dcmd.show_entry |-> (rank_q != '0) && (rank_q <= emit_n))
    else $error("dumped rank out of range");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    dcmd.accept && (cmd.action == spq_pkg::ACT_CLEAR) |=> count == '0)
    else $error("clear left entries behind");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> count == $past(count) + CW'(1))
    else $error("insert did not add one entry");

endmodule

`default_nettype wire

>>> hdl/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  input  wire logic [spq_pkg::ACTION_W-1:0] cmd_action,
  output logic                       cmd_ready,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  input  wire spq_pkg::dp_stat_t     dstat,
  output spq_pkg::dp_cmd_t           dcmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd_action)
            spq_pkg::ACT_INSERT: state_next = spq_pkg::ST_REPLY;
            spq_pkg::ACT_CLEAR:  state_next = spq_pkg::ST_REPLY;
            spq_pkg::ACT_DUMP:
              state_next = dstat.empty ? spq_pkg::ST_REPLY : spq_pkg::ST_DUMP;
            default:             state_next = spq_pkg::ST_IDLE;
          endcase
        end
      end
      spq_pkg::ST_REPLY: begin
        if (res_ready) begin
          state_next = spq_pkg::ST_IDLE;
        end
      end
      spq_pkg::ST_DUMP: begin
        // After the last emitted entry the shift line keeps turning until
        // every slot is back at its own place.
        if (res_ready && dstat.dump_last) begin
          state_next = dstat.rot_last ? spq_pkg::ST_IDLE : spq_pkg::ST_SPIN;
        end
      end
      spq_pkg::ST_SPIN: begin
        if (dstat.rot_last) begin
          state_next = spq_pkg::ST_IDLE;
        end
      end
      default: state_next = spq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready       = 1'b0;
    res_valid       = 1'b0;
    dcmd.accept     = 1'b0;
    dcmd.rotate     = 1'b0;
    dcmd.show_entry = 1'b0;
    case (state)
      spq_pkg::ST_IDLE: begin
        // No command is taken while reset is held.
        cmd_ready   = !rst;
        dcmd.accept = cmd_valid && !rst;
      end
      spq_pkg::ST_REPLY: begin
        res_valid = 1'b1;
      end
      spq_pkg::ST_DUMP: begin
        res_valid       = 1'b1;
        dcmd.show_entry = 1'b1;
        dcmd.rotate     = res_ready;
      end
      spq_pkg::ST_SPIN: begin
        dcmd.rotate = 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(cmd_ready && res_valid))
    else $error("command taken while a result is pending");

endmodule

`default_nettype wire

>>> hdl/sorted_priority_queue.sv
// Channel  Direction  Handshake               Payload
// cmd      in         cmd_valid / cmd_ready   spq_pkg::cmd_item_t
// res      out        res_valid / res_ready   spq_pkg::res_item_t
//
// Insert, clear and a dump of an empty queue do their work in the transfer
// cycle; the single result is offered from the next cycle on.
// A dump of a non-empty queue shows one entry per cycle while res_ready is
// high, from the head of a rotating shift line, and then finishes the
// rotation.
// Reset empties the queue at once; slot contents are not cleared.
// A stall on res holds the result and the rotation; no command is taken
// until the last result of the current one has been transferred.
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire spq_pkg::cmd_item_t cmd,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output spq_pkg::res_item_t      res
);

  spq_pkg::dp_cmd_t  dcmd;
  spq_pkg::dp_stat_t dstat;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_action (cmd.action),
    .cmd_ready  (cmd_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .dstat      (dstat),
    .dcmd       (dcmd)
  );

  spq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .dcmd  (dcmd),
    .dstat (dstat),
    .res   (res)
  );

endmodule

`default_nettype wire
